[sv/clt_pkg.sv]
// clt_pkg: types shared by the tokenizer front, queue and back, plus the
// character codes and per-byte step the front runs. Depends on nothing.
`default_nettype none

package clt_pkg;

  // Characters recognised by the tokenizer
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [4:0] MAX_FIELDS_RESET = 5'd16;

  // Most results one byte can cause, and the bundle queue depth
  localparam int unsigned RES_MAX = 4;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_UNQ   = 3'd1,
    MODE_QUO   = 3'd2,
    MODE_QPEND = 3'd3,
    MODE_DONE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_last;
  } line_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [4:0] field_index;
    logic       last;
  } tok_item_t;

  // Results of one byte; the final valid entry carries last = 1
  typedef tok_item_t [RES_MAX-1:0] bundle_t;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] count;
    logic [2:0] n;
    bundle_t    res;
  } step_t;

  function automatic step_t emit(step_t s, kind_t kind, logic [7:0] b, logic [4:0] idx);
    if (s.n < 3'(RES_MAX)) begin
      s.res[s.n[1:0]] = '{kind: kind, out_byte: b, field_index: idx, last: 1'b0};
      s.n = s.n + 3'd1;
    end
    return s;
  endfunction

  function automatic step_t row_end(step_t s);
    if (s.mode != MODE_DONE) begin
      s = emit(s, KIND_ROW_END, 8'd0, s.count);
      s.mode = MODE_DONE;
    end
    return s;
  endfunction

  function automatic step_t field_end(step_t s, logic [4:0] limit);
    s = emit(s, KIND_FIELD_END, 8'd0, s.count);
    s.count = s.count + 5'd1;
    s.mode = MODE_START;
    if (s.count >= limit) s = row_end(s);
    return s;
  endfunction

  function automatic step_t at_start(step_t s, logic [7:0] b, logic [4:0] limit);
    if (s.count >= limit || b == CH_LF || b == CH_CR) begin
      s = row_end(s);
    end else if (b == CH_QUOTE) begin
      s.mode = MODE_QUO;
    end else if (b == CH_COMMA) begin
      s = field_end(s, limit);
    end else begin
      s = emit(s, KIND_CHAR, b, s.count);
      s.mode = MODE_UNQ;
    end
    return s;
  endfunction

  // One input byte: new state and up to four results
  function automatic step_t step(mode_t mode, logic [4:0] count, logic [7:0] b,
                                 logic fin, logic [4:0] limit);
    step_t s;
    s = '{mode: mode, count: count, n: 3'd0, res: '0};
    unique case (mode)
      MODE_START: s = at_start(s, b, limit);
      MODE_UNQ: begin
        if (b == CH_COMMA) begin
          s = field_end(s, limit);
        end else if (b == CH_LF || b == CH_CR) begin
          s = field_end(s, limit);
          s = row_end(s);
        end else begin
          s = emit(s, KIND_CHAR, b, s.count);
        end
      end
      MODE_QUO: begin
        if (b == CH_QUOTE) s.mode = MODE_QPEND;
        else s = emit(s, KIND_CHAR, b, s.count);
      end
      MODE_QPEND: begin
        if (b == CH_QUOTE) begin
          s = emit(s, KIND_CHAR, b, s.count);
          s.mode = MODE_QUO;
        end else begin
          s = field_end(s, limit);
          if (s.mode != MODE_DONE && b != CH_COMMA) s = at_start(s, b, limit);
        end
      end
      default: s.mode = MODE_DONE;
    endcase
    if (fin) begin
      if (s.mode == MODE_UNQ || s.mode == MODE_QUO || s.mode == MODE_QPEND)
        s = field_end(s, limit);
      s = row_end(s);
      s.mode = MODE_START;
      s.count = 5'd0;
    end
    if (s.n != 3'd0) s.res[2'(s.n - 3'd1)].last = 1'b1;
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/clt_front.sv]
// clt_front: accepts line bytes, runs the tokenizer state and builds the
// bundle of results for each byte. Depends on clt_pkg.
`default_nettype none

module clt_front #(
  parameter int MAX_FIELDS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 line_valid,
  output logic                line_ready,
  input  clt_pkg::line_item_t line,
  input  wire                 cfg_wen,
  input  wire  [4:0]          cfg_wdata,
  output logic                push_valid,
  input  wire                 push_ready,
  output clt_pkg::bundle_t    push_data
);

  localparam logic [4:0] LimitCap = 5'((MAX_FIELDS > 31) ? 31 : MAX_FIELDS);

  clt_pkg::mode_t mode;
  logic [4:0]     count;
  logic [4:0]     max_fields;
  logic [4:0]     limit;
  clt_pkg::step_t nxt;
  logic           take;

  always_comb begin
    limit      = (max_fields < LimitCap) ? max_fields : LimitCap;
    nxt        = clt_pkg::step(mode, count, line.line_byte, line.line_last, limit);
    line_ready = push_ready;
    take       = line_valid && line_ready;
    push_valid = take && (nxt.n != 3'd0);
    push_data  = nxt.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= clt_pkg::MODE_START;
      count      <= 5'd0;
      max_fields <= clt_pkg::MAX_FIELDS_RESET;
    end else begin
      if (cfg_wen) max_fields <= cfg_wdata;
      if (take) begin
        mode  <= nxt.mode;
        count <= nxt.count;
      end
    end
  end

endmodule

`default_nettype wire

[sv/clt_queue.sv]
// clt_queue: short FIFO of result bundles between tokenizer front and back.
// Depends on clt_pkg.
`default_nettype none

module clt_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  output logic             push_ready,
  input  clt_pkg::bundle_t push_data,
  output logic             pop_valid,
  input  wire              pop,
  output clt_pkg::bundle_t pop_data
);

  clt_pkg::bundle_t                mem [clt_pkg::QDEPTH];
  logic [clt_pkg::QPTR_W-1:0]      wr_ptr;
  logic [clt_pkg::QPTR_W-1:0]      rd_ptr;
  logic [clt_pkg::QPTR_W:0]        fill;
  logic                            do_push;
  logic                            do_pop;

  always_comb begin
    push_ready = (fill != (clt_pkg::QPTR_W+1)'(clt_pkg::QDEPTH));
    pop_valid  = (fill != '0);
    pop_data   = mem[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop && pop_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

[sv/clt_back.sv]
// clt_back: walks the head bundle of the queue and hands out one token per
// request. Depends on clt_pkg.
`default_nettype none

module clt_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                head_valid,
  input  clt_pkg::bundle_t   head,
  output logic               pop,
  output logic               tok_valid,
  input  wire                tok_ready,
  output clt_pkg::tok_item_t tok
);

  logic [1:0] slot;
  logic       sent;

  always_comb begin
    tok       = head[slot];
    tok_valid = head_valid;
    sent      = tok_valid && tok_ready;
    // release the bundle once its final token has gone
    pop       = sent && tok.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 2'd0;
    end else if (sent) begin
      slot <= tok.last ? 2'd0 : slot + 2'd1;
    end
  end

endmodule

`default_nettype wire

[sv/csv_line_tokenizer.sv]
// csv_line_tokenizer: top level of the CSV line tokenizer.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
//
// Usage:
//  - line channel (line_valid/line_ready/line): one request per raw byte of a
//    CSV line, line_last set on the final byte of the line.
//  - tok channel (tok_valid/tok_ready/tok): one request per token: a field
//    character, an end of field or an end of row carrying the field count;
//    tok.last marks the final token caused by a byte.
//  - cfg_wen/cfg_wdata: write max_fields (resets to 16). Write only while the
//    block is idle. The limit in force is the smaller of it and MAX_FIELDS.
// The first token of a byte is offered once its bundle is registered in
// the queue and the bundles ahead of it have gone. Throughput: one byte
// per cycle while bytes yield at most one token each and tok_ready is high;
// the tok port gives one token per cycle, so a byte's tokens leave in turn.
// A four-entry queue of per-byte bundles sets how far bytes can run ahead.
// Reset: clears the parser to field start, count zero, and empties the queue.
// Stall: while tok_ready is low, tokens hold; the byte side keeps taking
// bytes until the queue fills, then line_ready drops.
`default_nettype none

module csv_line_tokenizer #(
  parameter int MAX_FIELDS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 line_valid,
  output logic                line_ready,
  input  clt_pkg::line_item_t line,
  output logic                tok_valid,
  input  wire                 tok_ready,
  output clt_pkg::tok_item_t  tok,
  input  wire                 cfg_wen,
  input  wire  [4:0]          cfg_wdata
);

  // front -> queue
  logic             push_valid;
  logic             push_ready;
  clt_pkg::bundle_t push_data;

  // queue -> back
  logic             head_valid;
  logic             pop;
  clt_pkg::bundle_t head;

  // Parse each byte combinationally and form its token bundle
  clt_front #(
    .MAX_FIELDS(MAX_FIELDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .line_valid(line_valid),
    .line_ready(line_ready),
    .line      (line),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  // Hold bundles so parsing and output stall independently
  clt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (head_valid),
    .pop       (pop),
    .pop_data  (head)
  );

  // Serialise each bundle, one token per cycle while tok_ready is high
  clt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

endmodule

`default_nettype wire
